>>> rtl/cso_pkg.sv
package cso_pkg;

	// Frame defaults
	localparam int FRAME_WIDTH_DEF  = 640;
	localparam int FRAME_HEIGHT_DEF = 480;

	// Field widths
	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int PIX_W   = 32;
	localparam int POS_W   = 12;
	localparam int CRD_W   = 13;  // wide enough for a frame size of 4096
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = POS_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_VISIBLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_BUTTON  = 3'd3;

	// Sprite geometry
	localparam int SPR_W = 12;
	localparam int SPR_H = 18;
	localparam int SPR_DX_W = 4;
	localparam int SPR_DY_W = 5;

	// Cursor colors
	localparam logic [PIX_W-1:0] COLOR_OUTLINE       = 32'h0003_0A10;
	localparam logic [PIX_W-1:0] COLOR_FILL_PRESSED  = 32'h0038_BDF8;
	localparam logic [PIX_W-1:0] COLOR_FILL_RELEASED = 32'h00F8_FAFC;

	typedef struct packed {
		logic [COL_W-1:0] pixel_col;
		logic [ROW_W-1:0] pixel_row;
		logic [PIX_W-1:0] source_pixel;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             cursor_hit;
	} out_item_t;

	// Cursor settings, position already clamped to the frame
	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             visible;
		logic             button;
	} cursor_cfg_t;

	// Outline mask of one sprite row; bit k is sprite column k
	function automatic logic [SPR_W-1:0] spr_outline(input logic [SPR_DY_W-1:0] dy);
		logic [SPR_W-1:0] m;
		case (dy)
			5'd0:    m = 12'h001;
			5'd1:    m = 12'h003;
			5'd2:    m = 12'h005;
			5'd3:    m = 12'h009;
			5'd4:    m = 12'h011;
			5'd5:    m = 12'h021;
			5'd6:    m = 12'h041;
			5'd7:    m = 12'h081;
			5'd8:    m = 12'h101;
			5'd9:    m = 12'h201;
			5'd10:   m = 12'h3E1;
			5'd11:   m = 12'h029;
			5'd12:   m = 12'h055;
			5'd13:   m = 12'h053;
			5'd14:   m = 12'h0A1;
			5'd15:   m = 12'h0A0;
			5'd16:   m = 12'h0A0;
			5'd17:   m = 12'h0E0;
			default: m = '0;
		endcase
		return m;
	endfunction

	// Fill mask of one sprite row
	function automatic logic [SPR_W-1:0] spr_fill(input logic [SPR_DY_W-1:0] dy);
		logic [SPR_W-1:0] m;
		case (dy)
			5'd2:    m = 12'h002;
			5'd3:    m = 12'h006;
			5'd4:    m = 12'h00E;
			5'd5:    m = 12'h01E;
			5'd6:    m = 12'h03E;
			5'd7:    m = 12'h07E;
			5'd8:    m = 12'h0FE;
			5'd9:    m = 12'h1FE;
			5'd10:   m = 12'h01E;
			5'd11:   m = 12'h016;
			5'd12:   m = 12'h022;
			5'd13:   m = 12'h020;
			5'd14:   m = 12'h040;
			5'd15:   m = 12'h040;
			5'd16:   m = 12'h040;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/cso_cfg_regs.sv
module cso_cfg_regs
	import cso_pkg::*;
#(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cursor_cfg_t           cursor
);

	localparam logic [CRD_W-1:0] X_MAX = CRD_W'(FRAME_WIDTH - 1);
	localparam logic [CRD_W-1:0] Y_MAX = CRD_W'(FRAME_HEIGHT - 1);

	cursor_cfg_t cursor_q;
	logic [CRD_W-1:0] wdata_w;

	assign wdata_w = {1'b0, cfg_wdata};

	// Register file; positions are clamped as they are written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CURSOR_X: begin
					cursor_q.x <= (wdata_w > X_MAX) ? X_MAX[POS_W-1:0] : cfg_wdata;
				end
				CFG_CURSOR_Y: begin
					cursor_q.y <= (wdata_w > Y_MAX) ? Y_MAX[POS_W-1:0] : cfg_wdata;
				end
				CFG_CURSOR_VISIBLE: begin
					cursor_q.visible <= cfg_wdata[0];
				end
				CFG_CURSOR_BUTTON: begin
					cursor_q.button <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cursor = cursor_q;

endmodule

>>> rtl/cso_blend.sv
module cso_blend
	import cso_pkg::*;
#(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  in_item_t    pixel,
	input  cursor_cfg_t cursor,
	output out_item_t   result
);

	localparam logic [CRD_W-1:0] FW    = CRD_W'(FRAME_WIDTH);
	localparam logic [CRD_W-1:0] FH    = CRD_W'(FRAME_HEIGHT);
	localparam logic [CRD_W-1:0] SPR_WC = CRD_W'(SPR_W);
	localparam logic [CRD_W-1:0] SPR_HC = CRD_W'(SPR_H);

	logic [CRD_W-1:0] col_w, row_w, cx_w, cy_w, dx_w, dy_w;
	logic             in_box;
	logic [SPR_W-1:0] outline_row, fill_row;
	logic             is_outline, is_fill;

	assign col_w = CRD_W'(pixel.pixel_col);
	assign row_w = CRD_W'(pixel.pixel_row);
	assign cx_w  = CRD_W'(cursor.x);
	assign cy_w  = CRD_W'(cursor.y);
	assign dx_w  = col_w - cx_w;
	assign dy_w  = row_w - cy_w;

	// Pixel lies inside the frame and inside the sprite box
	assign in_box = cursor.visible && (col_w < FW) && (row_w < FH) &&
		(col_w >= cx_w) && (row_w >= cy_w) && (dx_w < SPR_WC) && (dy_w < SPR_HC);

	// Shape lookup; outline wins over fill
	assign outline_row = spr_outline(dy_w[SPR_DY_W-1:0]);
	assign fill_row    = spr_fill(dy_w[SPR_DY_W-1:0]);
	assign is_outline  = in_box && outline_row[dx_w[SPR_DX_W-1:0]];
	assign is_fill     = in_box && fill_row[dx_w[SPR_DX_W-1:0]];

	always_comb begin
		result.cursor_hit = is_outline || is_fill;
		if (is_outline) begin
			result.out_pixel = COLOR_OUTLINE;
		end else if (is_fill) begin
			result.out_pixel = cursor.button ? COLOR_FILL_PRESSED : COLOR_FILL_RELEASED;
		end else begin
			result.out_pixel = pixel.source_pixel;
		end
	end

endmodule

>>> rtl/cursor_sprite_overlay_unit.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_item_t  (col, row, source pixel)
// out       output     out_valid / out_stall out_item_t (pixel, cursor hit)
// cfg       input      cfg_we                cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low; an item passes through
// the input register, then the result register, from which it leaves.
// Reset clears the cursor registers and both valid flags.
// A stall on the output holds the result register; the input register
// still fills while it is empty, so in_stall rises only when both are full.
module cursor_sprite_overlay_unit
	import cso_pkg::*;
#(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cursor_cfg_t cursor;
	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   result;
	out_item_t   item_s2;
	logic        valid_s2;
	logic        adv_s1, adv_s2;

	cso_cfg_regs #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cursor    (cursor)
	);

	// Stage enables
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= in_item;
		end
	end

	cso_blend #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_blend (
		.pixel  (item_s1),
		.cursor (cursor),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			item_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// A hit always carries one of the cursor colors
	a_hit_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.cursor_hit |->
			(out_item.out_pixel == COLOR_OUTLINE ||
			 out_item.out_pixel == COLOR_FILL_PRESSED ||
			 out_item.out_pixel == COLOR_FILL_RELEASED))
		else $error("cursor hit with a non-cursor color");

	// Clamped cursor position stays inside the frame
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(CRD_W'(cursor.x) < CRD_W'(FRAME_WIDTH)) && (CRD_W'(cursor.y) < CRD_W'(FRAME_HEIGHT)))
		else $error("cursor position outside the frame");

	// A hidden cursor never replaces a pixel
	a_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && !cursor.visible |=> !out_item.cursor_hit)
		else $error("hidden cursor produced a hit");

	// Input is held off only when both registers are occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule

>>> bench/overlay_checker.sv
module overlay_checker
	import cso_pkg::*;
#(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_item_t              in_item,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    pending
);

	typedef enum logic [1:0] {CELL_CLEAR, CELL_EDGE, CELL_BODY} arrow_cell_t;

	// Local copy of the cursor registers, as written
	logic [POS_W-1:0] req_x;
	logic [POS_W-1:0] req_y;
	logic             show;
	logic             pressed;

	out_item_t composite_q[$];
	int        fail_total;

	// Arrow rows packed as {body mask, edge mask}; bit k is sprite column k
	function automatic logic [23:0] arrow_row(input int dy);
		case (dy)
			0:       return 24'h000_001;
			1:       return 24'h000_003;
			2:       return 24'h002_005;
			3:       return 24'h006_009;
			4:       return 24'h00E_011;
			5:       return 24'h01E_021;
			6:       return 24'h03E_041;
			7:       return 24'h07E_081;
			8:       return 24'h0FE_101;
			9:       return 24'h1FE_201;
			10:      return 24'h01E_3E1;
			11:      return 24'h016_029;
			12:      return 24'h022_055;
			13:      return 24'h020_053;
			14:      return 24'h040_0A1;
			15:      return 24'h040_0A0;
			16:      return 24'h040_0A0;
			17:      return 24'h000_0E0;
			default: return 24'h000_000;
		endcase
	endfunction

	function automatic arrow_cell_t arrow_lookup(input int dx, input int dy);
		logic [23:0] r;
		if (dx < 0 || dx >= SPR_W || dy < 0 || dy >= SPR_H)
			return CELL_CLEAR;
		r = arrow_row(dy);
		if (r[dx])
			return CELL_EDGE;
		if (r[12 + dx])
			return CELL_BODY;
		return CELL_CLEAR;
	endfunction

	// Expected composited pixel under the current cursor settings
	function automatic out_item_t composite(input in_item_t px);
		int          cx;
		int          cy;
		int          col;
		int          row;
		arrow_cell_t shape;
		out_item_t   r;
		cx = (int'(req_x) < FRAME_WIDTH) ? int'(req_x) : FRAME_WIDTH - 1;
		cy = (int'(req_y) < FRAME_HEIGHT) ? int'(req_y) : FRAME_HEIGHT - 1;
		col = int'(px.pixel_col);
		row = int'(px.pixel_row);
		r.out_pixel = px.source_pixel;
		r.cursor_hit = 1'b0;
		shape = CELL_CLEAR;
		if (show && col < FRAME_WIDTH && row < FRAME_HEIGHT)
			shape = arrow_lookup(col - cx, row - cy);
		case (shape)
			CELL_EDGE: begin
				r.out_pixel = COLOR_OUTLINE;
				r.cursor_hit = 1'b1;
			end
			CELL_BODY: begin
				r.out_pixel = pressed ? COLOR_FILL_PRESSED : COLOR_FILL_RELEASED;
				r.cursor_hit = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// One line per mismatch, and count it
	task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
			input logic [PIX_W-1:0] want);
		fail_total++;
		$display("mismatch: %s at %0t, got %h, expected %h", what, $time, got, want);
	endtask

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			req_x = '0;
			req_y = '0;
			show = 1'b0;
			pressed = 1'b0;
			composite_q.delete();
			fail_total = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// result side first: an item accepted now cannot be its source
			if (out_valid && !out_stall) begin
				if (composite_q.size() == 0) begin
					report_mismatch("result with nothing expected", out_item.out_pixel, '0);
				end else begin
					want = composite_q.pop_front();
					if (out_item.out_pixel !== want.out_pixel)
						report_mismatch("out_pixel", out_item.out_pixel, want.out_pixel);
					if (out_item.cursor_hit !== want.cursor_hit)
						report_mismatch("cursor_hit", PIX_W'(out_item.cursor_hit),
							PIX_W'(want.cursor_hit));
				end
			end
			if (in_valid && !in_stall)
				composite_q.push_back(composite(in_item));
			// register writes, masked to their widths; other indexes do nothing
			if (cfg_we) begin
				case (cfg_index)
					CFG_CURSOR_X:       req_x = cfg_wdata;
					CFG_CURSOR_Y:       req_y = cfg_wdata;
					CFG_CURSOR_VISIBLE: show = cfg_wdata[0];
					CFG_CURSOR_BUTTON:  pressed = cfg_wdata[0];
					default: ;
				endcase
			end
			mismatches <= fail_total;
			pending <= composite_q.size();
		end
	end

endmodule

>>> bench/tb.sv
module tb;
	import cso_pkg::*;

	typedef enum {
		PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH, PACE_BACKPRESSURE
	} pace_t;

	localparam int HOLD_CYCLES = 48;
	localparam int PHASE_ITEMS = 125;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_USED = CFG_CURSOR_BUTTON;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    pending;

	pace_t pace;
	int    aim_x;
	int    aim_y;

	cursor_sprite_overlay_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	overlay_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int send_idle_pct(input pace_t p);
		case (p)
			PACE_SEND_IDLE: return 81;
			PACE_BOTH:      return 7;
			default:        return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input pace_t p);
		case (p)
			PACE_RECV_STALL: return 81;
			PACE_BOTH:       return 7;
			default:         return 0;
		endcase
	endfunction

	// Display side: random stalls, or long hold-offs counted here
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (pace == PACE_BACKPRESSURE) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				repeat (8) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct(pace));
			end
		end
	end

	function automatic in_item_t pixel_at(input int col, input int row,
			input logic [PIX_W-1:0] src);
		in_item_t it;
		it.pixel_col = COL_W'(col);
		it.pixel_row = ROW_W'(row);
		it.source_pixel = src;
		return it;
	endfunction

	// Mostly pixels around the sprite, the rest anywhere the fields reach
	function automatic in_item_t random_pixel();
		logic [PIX_W-1:0] src;
		case ($urandom_range(9))
			0:       src = '0;
			1:       src = '1;
			default: src = $urandom;
		endcase
		if ($urandom_range(9) < 7)
			return pixel_at(aim_x + $urandom_range(14) - 1, aim_y + $urandom_range(20) - 1, src);
		return pixel_at($urandom_range(1023), $urandom_range(511), src);
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(input int lim);
		case ($urandom_range(5))
			0:       return '0;
			1:       return POS_W'(lim - 1);
			2:       return POS_W'(lim);
			3:       return '1;
			default: return POS_W'($urandom_range(lim - 1));
		endcase
	endfunction

	// Leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// All four registers, then a write to an unused index that must change nothing
	task automatic set_cursor(input logic [CFG_DATA_W-1:0] x, input logic [CFG_DATA_W-1:0] y,
			input logic [CFG_DATA_W-1:0] vis, input logic [CFG_DATA_W-1:0] btn);
		write_reg(CFG_CURSOR_X, x);
		write_reg(CFG_CURSOR_Y, y);
		write_reg(CFG_CURSOR_VISIBLE, vis);
		write_reg(CFG_CURSOR_BUTTON, btn);
		write_reg(CFG_IDX_W'($urandom_range(CFG_TOP_INDEX, CFG_LAST_USED + 1)),
			CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		aim_x = (int'(x) < FRAME_WIDTH_DEF) ? int'(x) : FRAME_WIDTH_DEF - 1;
		aim_y = (int'(y) < FRAME_HEIGHT_DEF) ? int'(y) : FRAME_HEIGHT_DEF - 1;
	endtask

	// Offer one pixel, hold it until taken, then maybe go idle
	task automatic send_pixel(input in_item_t it);
		int pct;
		pct = send_idle_pct(pace);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		if ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
	endtask

	// Wait until every expected pixel is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] vis;
		logic [CFG_DATA_W-1:0] btn;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pace = PACE_FREE;
		aim_x = 0;
		aim_y = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: cursor hidden, so the arrow tip passes through
		send_pixel(pixel_at(0, 0, 32'hFFFF_FFFF));
		send_pixel(pixel_at(1, 2, 32'h0000_0000));
		drain();

		// cursor at the origin, released
		set_cursor(12'd0, 12'd0, 12'd1, 12'd0);
		send_pixel(pixel_at(0, 0, 32'h0000_0000));
		send_pixel(pixel_at(1, 2, 32'hFFFF_FFFF));
		send_pixel(pixel_at(9, 10, 32'h1234_5678));
		send_pixel(pixel_at(11, 17, 32'hFFFF_FFFF));
		send_pixel(pixel_at(12, 0, 32'hA5A5_5A5A));
		send_pixel(pixel_at(1023, 511, 32'hFFFF_FFFF));
		send_pixel(pixel_at(639, 479, 32'h0000_0000));
		drain();

		// pressed button changes the body color
		set_cursor(12'd0, 12'd0, 12'd1, 12'd1);
		send_pixel(pixel_at(1, 2, 32'h0000_0000));
		send_pixel(pixel_at(6, 14, 32'hFFFF_FFFF));
		drain();

		// position far beyond the frame is clamped to the last pixel
		set_cursor(12'hFFF, 12'hFFF, 12'd1, 12'd0);
		send_pixel(pixel_at(639, 479, 32'hFFFF_FFFF));
		send_pixel(pixel_at(638, 479, 32'h0000_0000));
		send_pixel(pixel_at(640, 479, 32'h0000_0000));
		send_pixel(pixel_at(639, 480, 32'hFFFF_FFFF));
		drain();

		// position exactly at the frame size is clamped too
		set_cursor(12'd640, 12'd480, 12'd1, 12'd1);
		send_pixel(pixel_at(639, 479, 32'h0F0F_F0F0));
		drain();

		// sprite clipped at the right and bottom edges
		set_cursor(12'd633, 12'd470, 12'd1, 12'd1);
		send_pixel(pixel_at(634, 479, 32'h0000_0000));
		send_pixel(pixel_at(639, 479, 32'hFFFF_FFFF));
		drain();

		// only bit 0 of visible counts: upper bits set, cursor still hidden
		set_cursor(12'd100, 12'd50, 12'hFFE, 12'hFFF);
		send_pixel(pixel_at(100, 50, 32'hCAFE_0001));
		drain();
		set_cursor(12'd100, 12'd50, 12'hFFF, 12'hFFE);
		send_pixel(pixel_at(100, 50, 32'h0000_0000));
		send_pixel(pixel_at(102, 54, 32'h0000_0000));
		drain();

		// random phases, one pacing mode each, last one random
		for (int ph = 0; ph < 6; ph++) begin
			vis = CFG_DATA_W'($urandom);
			btn = CFG_DATA_W'($urandom);
			vis[0] = ($urandom_range(9) != 0);
			set_cursor(pick_pos(FRAME_WIDTH_DEF), pick_pos(FRAME_HEIGHT_DEF), vis, btn);
			pace = (ph < 5) ? pace_t'(ph) : pace_t'($urandom_range(4));
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pixel(random_pixel());
			drain();
			pace = PACE_FREE;
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
